>>> hdl/svd_pkg.sv
package svd_pkg;

  localparam int ANGLE_W         = 9;
  localparam int SAMPLE_W        = 12;
  localparam int SCORE_W         = 20;
  localparam int FRAC_W          = 8;
  localparam int HALF_WINDOW_DEF = 2;
  // quotient bits resolved per divider cycle
  localparam int DIV_STEP        = 4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [ANGLE_W-1:0]  angle;
  } point_t;

  typedef struct packed {
    logic clear;
    logic shift_in;
    logic rotate;
  } chain_ctrl_t;

endpackage

>>> hdl/svd_ifs.sv
interface svd_in_if;
  logic                          valid;
  logic                          ready;
  logic [svd_pkg::ANGLE_W-1:0]   angle;
  logic [svd_pkg::SAMPLE_W-1:0]  sample_a;
  logic [svd_pkg::SAMPLE_W-1:0]  sample_b;
  logic                          last;

  modport source (output valid, angle, sample_a, sample_b, last, input ready);
  modport sink   (input valid, angle, sample_a, sample_b, last, output ready);
endinterface

interface svd_out_if;
  logic                          valid;
  logic                          ready;
  logic [svd_pkg::ANGLE_W-1:0]   source_angle;
  logic [svd_pkg::SCORE_W-1:0]   score;
  logic                          found;
  logic                          end_of_scan;

  modport source (output valid, source_angle, score, found, end_of_scan, input ready);
  modport sink   (input valid, source_angle, score, found, end_of_scan, output ready);
endinterface

>>> hdl/svd_cell.sv
module svd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  svd_pkg::chain_ctrl_t ctrl,
  input  svd_pkg::point_t      from_prev,
  input  svd_pkg::point_t      from_next,
  output svd_pkg::point_t      pt
);

  svd_pkg::point_t pt_r;
  svd_pkg::point_t pt_nxt;

  always_comb begin
    pt_nxt = pt_r;
    if (ctrl.clear) begin
      pt_nxt = '0;
    end else if (ctrl.shift_in) begin
      pt_nxt = from_prev;
    end else if (ctrl.rotate) begin
      pt_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= '0;
    end else begin
      pt_r <= pt_nxt;
    end
  end

  assign pt = pt_r;

endmodule

>>> hdl/svd_divider.sv
module svd_divider #(
  parameter int SUM_W  = 15,
  parameter int DIVR_W = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [SUM_W-1:0]            sum,
  input  logic [DIVR_W-1:0]           divisor,
  output logic                        done,
  output logic [svd_pkg::SCORE_W-1:0] quotient
);

  localparam int DVD_W  = SUM_W + svd_pkg::FRAC_W;
  localparam int ITERS  = (DVD_W + svd_pkg::DIV_STEP - 1) / svd_pkg::DIV_STEP;
  localparam int PAD_W  = ITERS * svd_pkg::DIV_STEP;
  localparam int ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam int REM_W  = DIVR_W + 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] d_r, d_nxt;
  logic [PAD_W-1:0]  q_r, q_nxt;

  logic [PAD_W-1:0]  q_step;
  logic [REM_W-1:0]  r_step;

  // restoring long division, DIV_STEP quotient bits per cycle
  always_comb begin
    q_step = q_r;
    r_step = {1'b0, rem_r};
    for (int i = 0; i < svd_pkg::DIV_STEP; i++) begin
      r_step = {r_step[REM_W-2:0], q_step[PAD_W-1]};
      q_step = {q_step[PAD_W-2:0], 1'b0};
      if (r_step >= {1'b0, d_r}) begin
        r_step    = r_step - {1'b0, d_r};
        q_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ITER_W'(ITERS - 1);
      rem_nxt  = '0;
      d_nxt    = divisor;
      q_nxt    = PAD_W'({sum, {svd_pkg::FRAC_W{1'b0}}});
    end else if (busy_r) begin
      q_nxt   = q_step;
      rem_nxt = r_step[DIVR_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r[svd_pkg::SCORE_W-1:0];

endmodule

>>> hdl/smoothed_valley_detector.sv
// Smoothed valley detector. Takes one scan as points in ascending angle order,
// keeps the smaller of the two samples, smooths with a centered moving average
// of 2*HALF_WINDOW+1 points (shrunk at the scan ends, divided by the true
// count, 8 fraction bits, truncated) and reports strict local minima whose
// angle lies at least min_separation past the last reported one. The point
// with last set flushes the pending centers and is followed by a closing
// marker (found 0, end_of_scan 1); scan state then clears, min_separation is
// kept. The window sits in a row of cells that shifts once per point and then
// rotates once around, one cell per cycle, to form the sum; an iterative
// divider resolves four quotient bits per cycle. A point that yields a
// smoothed value passes through the sum, divide and push steps, an early
// point of a scan is only shifted in, and the last point repeats these steps
// for each flushed center and then sends the marker. A new point is taken
// while a result waits in the output register; the block stalls only when it
// must place a second result there.
module smoothed_valley_detector #(
  parameter int HALF_WINDOW = svd_pkg::HALF_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  svd_in_if.sink                      in_ch,
  svd_out_if.source                   out_ch,
  input  logic                        cfg_wr_en,
  input  logic [svd_pkg::ANGLE_W-1:0] cfg_wr_data
);

  localparam int W     = 2 * HALF_WINDOW + 1;
  localparam int IDX_W = $clog2(W);
  localparam int CNT_W = $clog2(W + 1);
  localparam int SUM_W = $clog2(W * ((1 << svd_pkg::SAMPLE_W) - 1) + 1);
  localparam int AW    = svd_pkg::ANGLE_W;
  localparam int SW    = svd_pkg::SCORE_W;

  localparam logic [CNT_W-1:0] W_C = CNT_W'(W);
  localparam logic [CNT_W-1:0] H_C = CNT_W'(HALF_WINDOW);
  localparam logic [IDX_W-1:0] K_LAST    = IDX_W'(W - 1);
  localparam logic [IDX_W-1:0] AIDX_CTR  = IDX_W'(HALF_WINDOW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_PUSH = 3'd3;
  localparam logic [2:0] ST_MARK = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] top_r, top_nxt;
  logic [IDX_W-1:0] aidx_r, aidx_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [AW-1:0]    pang_r, pang_nxt;
  logic [CNT_W-1:0] ps_r, ps_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  logic             last_r, last_nxt;
  logic             flush_r, flush_nxt;
  logic [SW-1:0]    hist0_r, hist0_nxt;
  logic [SW-1:0]    hist1_r, hist1_nxt;
  logic [1:0]       hv_r, hv_nxt;
  logic [AW-1:0]    la_r, la_nxt;
  logic             have_r, have_nxt;
  logic [AW-1:0]    minsep_r, minsep_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [AW-1:0]    oang_r, oang_nxt;
  logic [SW-1:0]    oscore_r, oscore_nxt;
  logic             ofound_r, ofound_nxt;
  logic             oeos_r, oeos_nxt;

  svd_pkg::chain_ctrl_t ctrl;
  svd_pkg::point_t      new_pt;
  svd_pkg::point_t      cells [W];

  logic             div_start;
  logic             div_done;
  logic [SW-1:0]    div_q;
  logic [SUM_W-1:0] acc_add;
  logic             accept;
  logic             out_free;
  logic             detect;
  logic [CNT_W-1:0] ps_inc;

  // flush job for a given countdown value
  logic [CNT_W-1:0] fj_p;
  logic [CNT_W-1:0] fj_ps;
  logic [CNT_W-1:0] fj_top_a;
  logic [CNT_W-1:0] fj_top_b;
  logic [IDX_W-1:0] fj_top;
  logic [CNT_W-1:0] fj_start;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign new_pt.sample = (in_ch.sample_a < in_ch.sample_b) ? in_ch.sample_a : in_ch.sample_b;
  assign new_pt.angle  = in_ch.angle;

  genvar g;
  generate
    for (g = 0; g < W; g++) begin : g_cell
      svd_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .from_prev ((g == 0) ? new_pt : cells[(g + W - 1) % W]),
        .from_next (cells[(g + 1) % W]),
        .pt        (cells[g])
      );
    end
  endgenerate

  svd_divider #(
    .SUM_W  (SUM_W),
    .DIVR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum      (acc_add),
    .divisor  (CNT_W'(top_r) + 1'b1),
    .done     (div_done),
    .quotient (div_q)
  );

  assign acc_add = acc_r + ((k_r <= top_r) ? SUM_W'(cells[0].sample) : '0);
  assign ps_inc  = (ps_r == W_C) ? W_C : ps_r + 1'b1;

  always_comb begin
    fj_ps    = (state_r == ST_IDLE) ? ps_inc : ps_r;
    fj_start = (fj_ps >= H_C) ? H_C : fj_ps;
    if (state_r == ST_PUSH && flush_r) begin
      fj_p = p_r - 1'b1;
    end else begin
      fj_p = fj_start;
    end
    fj_top_a = fj_p - 1'b1 + H_C;
    fj_top_b = fj_ps - 1'b1;
    fj_top   = (fj_top_a < fj_top_b) ? fj_top_a[IDX_W-1:0] : fj_top_b[IDX_W-1:0];
  end

  assign detect = (hv_r == 2'd2) && (hist0_r < hist1_r) && (div_q > hist0_r) &&
                  (!have_r || ((pang_r >= la_r) && ((pang_r - la_r) >= minsep_r)));

  assign div_start = (state_r == ST_SUM) && (k_r == K_LAST);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    top_nxt       = top_r;
    aidx_nxt      = aidx_r;
    acc_nxt       = acc_r;
    pang_nxt      = pang_r;
    ps_nxt        = ps_r;
    p_nxt         = p_r;
    last_nxt      = last_r;
    flush_nxt     = flush_r;
    hist0_nxt     = hist0_r;
    hist1_nxt     = hist1_r;
    hv_nxt        = hv_r;
    la_nxt        = la_r;
    have_nxt      = have_r;
    minsep_nxt    = cfg_wr_en ? cfg_wr_data : minsep_r;
    ctrl          = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    oang_nxt      = oang_r;
    oscore_nxt    = oscore_r;
    ofound_nxt    = ofound_r;
    oeos_nxt      = oeos_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctrl.shift_in = 1'b1;
          ps_nxt        = ps_inc;
          last_nxt      = in_ch.last;
          k_nxt         = '0;
          acc_nxt       = '0;
          if (ps_inc >= H_C + 1'b1) begin
            top_nxt   = IDX_W'(ps_inc - 1'b1);
            aidx_nxt  = AIDX_CTR;
            flush_nxt = 1'b0;
            state_nxt = ST_SUM;
          end else if (in_ch.last) begin
            flush_nxt = 1'b1;
            p_nxt     = fj_p;
            top_nxt   = fj_top;
            aidx_nxt  = IDX_W'(fj_p);
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        // rotate one cell per cycle; cell 0 holds window position k
        ctrl.rotate = 1'b1;
        acc_nxt     = acc_add;
        if (k_r == aidx_r) begin
          pang_nxt = cells[0].angle;
        end
        if (k_r == K_LAST) begin
          state_nxt = ST_DIV;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!detect || out_free) begin
          if (detect) begin
            out_valid_nxt = 1'b1;
            oang_nxt      = pang_r;
            oscore_nxt    = hist0_r;
            ofound_nxt    = 1'b1;
            oeos_nxt      = 1'b0;
            la_nxt        = pang_r;
            have_nxt      = 1'b1;
          end
          hist1_nxt = hist0_r;
          hist0_nxt = div_q;
          hv_nxt    = (hv_r == 2'd2) ? 2'd2 : hv_r + 1'b1;
          k_nxt     = '0;
          acc_nxt   = '0;
          if (flush_r && p_r == CNT_W'(1)) begin
            state_nxt = ST_MARK;
          end else if (flush_r || last_r) begin
            flush_nxt = 1'b1;
            p_nxt     = fj_p;
            top_nxt   = fj_top;
            aidx_nxt  = IDX_W'(fj_p);
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oang_nxt      = '0;
          oscore_nxt    = '0;
          ofound_nxt    = 1'b0;
          oeos_nxt      = 1'b1;
          ctrl.clear    = 1'b1;
          ps_nxt        = '0;
          hv_nxt        = '0;
          hist0_nxt     = '0;
          hist1_nxt     = '0;
          la_nxt        = '0;
          have_nxt      = 1'b0;
          flush_nxt     = 1'b0;
          last_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      ps_r        <= '0;
      p_r         <= '0;
      last_r      <= 1'b0;
      flush_r     <= 1'b0;
      hist0_r     <= '0;
      hist1_r     <= '0;
      hv_r        <= '0;
      la_r        <= '0;
      have_r      <= 1'b0;
      minsep_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      ps_r        <= ps_nxt;
      p_r         <= p_nxt;
      last_r      <= last_nxt;
      flush_r     <= flush_nxt;
      hist0_r     <= hist0_nxt;
      hist1_r     <= hist1_nxt;
      hv_r        <= hv_nxt;
      la_r        <= la_nxt;
      have_r      <= have_nxt;
      minsep_r    <= minsep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r    <= top_nxt;
    aidx_r   <= aidx_nxt;
    acc_r    <= acc_nxt;
    pang_r   <= pang_nxt;
    oang_r   <= oang_nxt;
    oscore_r <= oscore_nxt;
    ofound_r <= ofound_nxt;
    oeos_r   <= oeos_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.source_angle = oang_r;
  assign out_ch.score        = oscore_r;
  assign out_ch.found        = ofound_r;
  assign out_ch.end_of_scan  = oeos_r;

`ifndef SYNTHESIS
  a_ps_range: assert property (@(posedge clk) disable iff (!rst_n)
    ps_r <= W_C)
    else $error("points seen beyond window size");

  a_hv_range: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r <= 2'd2)
    else $error("smoothed history count beyond two");

  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ofound_r != oeos_r))
    else $error("result beat is neither detection nor marker");

  a_mark_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK && out_free) |=> (ps_r == '0 && !have_r && oeos_r))
    else $error("closing marker did not clear scan state");

  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide phase");
`endif

endmodule
